FILE: rtl/core/dlq_pkg.sv
package dlq_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int SLOT_W = $clog2(NUM_TIMERS);
	localparam int DELTA_W = 28;
	localparam int TOKEN_W = 16;
	localparam logic [DELTA_W-1:0] DELTA_MAX = {DELTA_W{1'b1}};

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_STOP   = 2'd1,
		MODE_EXPIRE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DISPATCH = 2'd0,
		KIND_PROGRAM  = 2'd1,
		KIND_STOP     = 2'd2,
		KIND_IDLE     = 2'd3
	} kind_t;

	typedef struct packed {
		mode_t               mode;
		logic [2:0]          timer_id;
		logic [31:0]         duration;
		logic [TOKEN_W-1:0]  event_token;
		logic [27:0]         elapsed;
	} req_t;

	typedef struct packed {
		kind_t               kind;
		logic [2:0]          expired_slot;
		logic [TOKEN_W-1:0]  token_out;
		logic [27:0]         head_delay;
		logic                last;
	} rsp_t;

	// one list entry; cell 0 is the head of the delta list
	typedef struct packed {
		logic                valid;
		logic [SLOT_W-1:0]   slot;
		logic [DELTA_W-1:0]  delta;
		logic [TOKEN_W-1:0]  token;
	} cell_t;

	typedef enum logic [1:0] {
		CMD_NOP = 2'd0,
		CMD_SHL = 2'd1,
		CMD_SHR = 2'd2,
		CMD_SUB = 2'd3
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [SLOT_W-1:0]   pos;
		logic                add;
		cell_t               entry;
		logic [DELTA_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNLINK,
		ST_START,
		ST_CONSUME,
		ST_WALK,
		ST_PROG,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/core/delta_list_timer_queue_core.sv
// Delta-list timer queue. Running timers sit in a row of cells in expiry order,
// cell 0 being the head; each cell holds its slot, token and the ticks past its
// predecessor. One transaction is accepted at a time on req and answered by one
// or more rsp transactions, the final one flagged by last. A stop unlinks the
// slot; an expiry retires the due timers from the head and then programs the
// new head delay; a start unlinks the slot and inserts directly into an empty
// list, otherwise retires the due timers, walks the list to the insert point,
// inserts and programs the head delay. The controller retires one dispatch per
// cycle while the output accepts and walks one cell per cycle to find the
// insert point. Output backpressure stalls the controller.
module delta_list_timer_queue_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  dlq_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output dlq_pkg::rsp_t   rsp
);
	import dlq_pkg::*;

	cell_t     cells [NUM_TIMERS];
	cell_cmd_t cmd;

	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		cell_t lft, rgt;
		if (i == 0) begin : g_first
			assign lft = '0;
		end else begin : g_mid_l
			assign lft = cells[i-1];
		end
		if (i == NUM_TIMERS - 1) begin : g_last
			assign rgt = '0;
		end else begin : g_mid_r
			assign rgt = cells[i+1];
		end
		dlq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (SLOT_W'(i)),
			.cmd    (cmd),
			.left   (lft),
			.right  (rgt),
			.q      (cells[i])
		);
	end

	dlq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cells     (cells),
		.cmd       (cmd)
	);

endmodule

FILE: rtl/core/dlq_cell.sv
module dlq_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [dlq_pkg::SLOT_W-1:0] idx,
	input  dlq_pkg::cell_cmd_t        cmd,
	input  dlq_pkg::cell_t            left,
	input  dlq_pkg::cell_t            right,
	output dlq_pkg::cell_t            q
);
	import dlq_pkg::*;

	cell_t              nxt;
	cell_t              ent_q;
	logic               valid_q;
	logic [DELTA_W:0]   sum;

	assign q = '{valid: valid_q, slot: ent_q.slot, delta: ent_q.delta, token: ent_q.token};
	assign sum = {1'b0, right.delta} + {1'b0, ent_q.delta};

	always_comb begin
		nxt = q;
		unique case (cmd.op)
			CMD_NOP: begin
			end
			// remove at pos: cells from pos upward take their right neighbor
			CMD_SHL: begin
				if (idx >= cmd.pos) begin
					nxt = right;
					if (idx == cmd.pos && cmd.add && right.valid)
						nxt.delta = sum[DELTA_W] ? DELTA_MAX : sum[DELTA_W-1:0];
				end
			end
			// insert at pos: the displaced successor gives up the new delta
			CMD_SHR: begin
				if (idx == cmd.pos) begin
					nxt = cmd.entry;
				end else if (idx > cmd.pos) begin
					nxt = left;
					if ((idx - 1'b1) == cmd.pos && left.valid)
						nxt.delta = left.delta - cmd.entry.delta;
				end
			end
			CMD_SUB: begin
				if (idx == cmd.pos)
					nxt.delta = q.delta - cmd.value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= nxt.valid;
	end

	always_ff @(posedge clk) begin
		ent_q <= nxt;
	end

endmodule

FILE: rtl/core/dlq_ctrl.sv
module dlq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  dlq_pkg::req_t        req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output dlq_pkg::rsp_t        rsp,
	input  dlq_pkg::cell_t       cells [dlq_pkg::NUM_TIMERS],
	output dlq_pkg::cell_cmd_t   cmd
);
	import dlq_pkg::*;

	state_t              state_q, state_d;
	req_t                item_q;
	logic [DELTA_W-1:0]  t_q, rem_q, acc_q;
	logic [SLOT_W-1:0]   k_q;
	logic                emitted_q;
	rsp_t                rsp_q, rsp_d;
	logic                rsp_valid_q;

	logic                accept, can_emit, emit;
	logic                id_ok, op_slot, stop_cond, hit, rem_ge, walk_go;
	logic [SLOT_W-1:0]   id, hit_pos;
	logic [NUM_TIMERS-1:0] match, vld;
	cell_t               c0, c1, wc;
	logic [DELTA_W:0]    walk_sum;
	logic [31:0]         dur16;
	logic [DELTA_W-1:0]  t_scaled;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign can_emit  = !rsp_valid_q || rsp_ready;

	assign dur16 = req.duration >> 4;
	always_comb begin
		if (dur16 == 32'd0)
			t_scaled = DELTA_W'(1);
		else if (dur16 > 32'(DELTA_MAX))
			t_scaled = DELTA_MAX;
		else
			t_scaled = DELTA_W'(dur16);
	end

	assign id      = SLOT_W'(item_q.timer_id);
	assign id_ok   = (32'(item_q.timer_id) < NUM_TIMERS);
	assign op_slot = id_ok && (item_q.mode == MODE_START || item_q.mode == MODE_STOP);
	assign c0      = cells[0];
	assign c1      = cells[1];
	assign wc      = cells[k_q];

	always_comb begin
		hit_pos = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			vld[i]   = cells[i].valid;
			match[i] = cells[i].valid && cells[i].slot == id;
			if (match[i])
				hit_pos = SLOT_W'(i);
		end
	end

	assign hit       = |match;
	assign stop_cond = c0.valid && c0.slot == id && !c1.valid;
	assign rem_ge    = c0.valid && rem_q >= c0.delta;
	assign walk_sum  = {1'b0, acc_q} + {1'b0, wc.delta};
	assign walk_go   = wc.valid && walk_sum <= {1'b0, t_q} &&
		k_q != SLOT_W'(NUM_TIMERS - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (accept)
					state_d = ST_UNLINK;
			ST_UNLINK: begin
				if (op_slot) begin
					if (!(stop_cond && !can_emit)) begin
						if (item_q.mode == MODE_START)
							state_d = ST_START;
						else
							state_d = stop_cond ? ST_IDLE : ST_FINISH;
					end
				end else if (item_q.mode == MODE_EXPIRE) begin
					state_d = ST_CONSUME;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_START:
				if (c0.valid)
					state_d = ST_CONSUME;
				else if (can_emit)
					state_d = ST_IDLE;
			ST_CONSUME:
				if (!rem_ge)
					state_d = (item_q.mode == MODE_START) ? ST_WALK : ST_PROG;
			ST_WALK:
				if (!walk_go)
					state_d = ST_PROG;
			ST_PROG:
				if (c0.valid) begin
					if (can_emit)
						state_d = ST_IDLE;
				end else begin
					state_d = emitted_q ? ST_IDLE : ST_FINISH;
				end
			ST_FINISH:
				if (can_emit)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit  = 1'b0;
		rsp_d = '{kind: KIND_IDLE, default: '0};
		cmd   = '{op: CMD_NOP, default: '0};
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_UNLINK: begin
				if (op_slot && !(stop_cond && !can_emit)) begin
					if (stop_cond) begin
						emit       = 1'b1;
						rsp_d.kind = KIND_STOP;
						rsp_d.last = (item_q.mode == MODE_STOP);
					end
					if (hit) begin
						cmd.op  = CMD_SHL;
						cmd.pos = hit_pos;
						cmd.add = 1'b1;
					end
				end
			end
			ST_START: begin
				if (!c0.valid && can_emit) begin
					cmd.op           = CMD_SHR;
					cmd.entry        = '{valid: 1'b1, slot: id, delta: t_q,
						token: item_q.event_token};
					emit             = 1'b1;
					rsp_d.kind       = KIND_PROGRAM;
					rsp_d.head_delay = 28'(t_q);
					rsp_d.last       = 1'b1;
				end
			end
			ST_CONSUME: begin
				if (rem_ge) begin
					if (can_emit) begin
						emit               = 1'b1;
						rsp_d.kind         = KIND_DISPATCH;
						rsp_d.expired_slot = 3'(c0.slot);
						rsp_d.token_out    = c0.token;
						// final only when an expiry empties the list
						rsp_d.last         = (item_q.mode == MODE_EXPIRE) && !c1.valid;
						cmd.op             = CMD_SHL;
					end
				end else if (c0.valid) begin
					cmd.op    = CMD_SUB;
					cmd.value = rem_q;
				end
			end
			ST_WALK: begin
				if (!walk_go) begin
					cmd.op    = CMD_SHR;
					cmd.pos   = k_q;
					cmd.entry = '{valid: 1'b1, slot: id, delta: t_q - acc_q,
						token: item_q.event_token};
				end
			end
			ST_PROG: begin
				if (c0.valid && can_emit) begin
					emit             = 1'b1;
					rsp_d.kind       = KIND_PROGRAM;
					rsp_d.head_delay = 28'(c0.delta);
					rsp_d.last       = 1'b1;
				end
			end
			ST_FINISH: begin
				if (can_emit) begin
					emit       = 1'b1;
					rsp_d.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			emitted_q   <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			if (accept) begin
				emitted_q <= 1'b0;
				k_q       <= '0;
			end else begin
				if (emit)
					emitted_q <= 1'b1;
				if (state_q == ST_WALK && walk_go)
					k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			rsp_q <= rsp_d;
		if (accept) begin
			item_q <= req;
			t_q    <= t_scaled;
			rem_q  <= req.elapsed;
			acc_q  <= '0;
		end else begin
			if (state_q == ST_CONSUME && rem_ge && can_emit)
				rem_q <= rem_q - c0.delta;
			if (state_q == ST_WALK && walk_go)
				acc_q <= walk_sum[DELTA_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_idle_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_IDLE |-> rsp.last)
		else $error("idle result without last");
	a_no_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> cmd.op == CMD_NOP)
		else $error("cell command while idle");
	a_list_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld} + 1'b1))
		else $error("delta list has a gap");
	a_slot_unique: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> $countones(match) <= 1)
		else $error("slot listed twice");
`endif

endmodule

FILE: dv/delta_list_timer_queue_core_tb.sv
`timescale 1ns / 1ps

module delta_list_timer_queue_core_tb;
	import dlq_pkg::*;

	localparam int EMPTY = NUM_TIMERS;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	delta_list_timer_queue_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// predictor state: delta list over the timer slots
	int unsigned head;
	int unsigned nxt[NUM_TIMERS];
	longint unsigned dlt[NUM_TIMERS];
	bit running[NUM_TIMERS];
	logic [15:0] tok[NUM_TIMERS];

	rsp_t pending_rsp[$];
	rsp_t batch[$];
	int mismatches = 0;
	int send_idle_pct = 32, recv_idle_pct = 61;
	longint cycles = 0;

	function automatic bit in_list(int unsigned s);
		return s < NUM_TIMERS;
	endfunction

	function automatic void push_rsp(kind_t k, int unsigned s, logic [15:0] t,
			longint unsigned d);
		rsp_t r;
		if (batch.size() >= 10)
			return;
		r = '0;
		r.kind = k;
		r.expired_slot = s[2:0];
		r.token_out = (k == KIND_DISPATCH) ? t : 16'd0;
		r.head_delay = d[27:0];
		batch.push_back(r);
	endfunction

	function automatic void remove_slot(int unsigned id);
		int unsigned prev, cur, succ;
		longint unsigned s;
		prev = EMPTY;
		cur = head;
		for (int n = 0; n < NUM_TIMERS && in_list(cur); n++) begin
			succ = nxt[cur];
			if (cur == id) begin
				if (in_list(prev))
					nxt[prev] = succ;
				else
					head = succ;
				if (in_list(succ)) begin
					s = dlt[succ] + dlt[cur];
					dlt[succ] = (s > DELTA_MAX) ? DELTA_MAX : s;
				end
				return;
			end
			prev = cur;
			cur = succ;
		end
	endfunction

	function automatic void run_down(longint unsigned rem);
		int unsigned cur;
		int n;
		cur = head;
		for (n = 0; n < NUM_TIMERS && in_list(cur); n++) begin
			if (rem >= dlt[cur]) begin
				running[cur] = 1'b0;
				rem -= dlt[cur];
				push_rsp(KIND_DISPATCH, cur, tok[cur], 0);
				cur = nxt[cur];
			end else begin
				dlt[cur] -= rem;
				break;
			end
		end
		if (n >= NUM_TIMERS && in_list(cur))
			cur = EMPTY;
		head = cur;
	endfunction

	function automatic void arm_timer(int unsigned id, logic [31:0] dur, logic [15:0] t,
			longint unsigned el);
		longint unsigned ticks, acc;
		int unsigned prev, cur;
		ticks = dur >> 4;
		acc = 0;
		prev = EMPTY;
		if (ticks == 0)
			ticks = 1;
		if (ticks > DELTA_MAX)
			ticks = DELTA_MAX;
		running[id] = 1'b0;
		if (head == id && !in_list(nxt[id]))
			push_rsp(KIND_STOP, 0, 0, 0);
		remove_slot(id);
		tok[id] = t;
		running[id] = 1'b1;
		if (!in_list(head)) begin
			head = id;
			nxt[id] = EMPTY;
			dlt[id] = ticks;
			push_rsp(KIND_PROGRAM, 0, 0, ticks);
			return;
		end
		run_down(el);
		cur = head;
		for (int n = 0; n < NUM_TIMERS && in_list(cur); n++) begin
			if (acc + dlt[cur] > ticks)
				break;
			acc += dlt[cur];
			prev = cur;
			cur = nxt[cur];
		end
		if (in_list(prev))
			nxt[prev] = id;
		else
			head = id;
		nxt[id] = in_list(cur) ? cur : EMPTY;
		dlt[id] = ticks - acc;
		if (in_list(cur))
			dlt[cur] -= dlt[id];
		push_rsp(KIND_PROGRAM, 0, 0, dlt[head]);
	endfunction

	// computes the responses of one request and queues them
	function automatic void predict_timer_rsp(req_t r);
		batch.delete();
		if (r.mode == MODE_START && r.timer_id < NUM_TIMERS) begin
			arm_timer(r.timer_id, r.duration, r.event_token, r.elapsed);
		end else if (r.mode == MODE_STOP && r.timer_id < NUM_TIMERS) begin
			running[r.timer_id] = 1'b0;
			if (head == r.timer_id && !in_list(nxt[r.timer_id]))
				push_rsp(KIND_STOP, 0, 0, 0);
			remove_slot(r.timer_id);
		end else if (r.mode == MODE_EXPIRE) begin
			run_down(r.elapsed);
			if (in_list(head))
				push_rsp(KIND_PROGRAM, 0, 0, dlt[head]);
		end
		if (batch.size() == 0)
			push_rsp(KIND_IDLE, 0, 0, 0);
		batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			pending_rsp.push_back(batch[i]);
	endfunction

	function automatic void note_mismatch(rsp_t exp_r, rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: exp kind=%0d slot=%0d tok=%h delay=%h last=%b %s",
				exp_r.kind, exp_r.expired_slot, exp_r.token_out, exp_r.head_delay,
				exp_r.last,
				$sformatf("/ got kind=%0d slot=%0d tok=%h delay=%h last=%b",
					got.kind, got.expired_slot, got.token_out, got.head_delay,
					got.last));
	endfunction

	// response side
	always @(posedge clk) begin
		rsp_t exp_r;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				note_mismatch('0, rsp);
			end else begin
				exp_r = pending_rsp.pop_front();
				if (rsp !== exp_r)
					note_mismatch(exp_r, rsp);
			end
		end
		if (arst_n)
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	typedef struct {
		req_t r;
		bit chk;
		rsp_t want;
	} stim_row_t;

	stim_row_t rows[$];

	function automatic req_t mk(mode_t m, int unsigned id, logic [31:0] d, logic [15:0] t,
			logic [27:0] el);
		req_t r;
		r.mode = m;
		r.timer_id = id[2:0];
		r.duration = d;
		r.event_token = t;
		r.elapsed = el;
		return r;
	endfunction

	function automatic rsp_t one(kind_t k, logic [27:0] d);
		rsp_t r;
		r = '0;
		r.kind = k;
		r.head_delay = d;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void add_row(req_t r, bit chk, rsp_t w);
		stim_row_t s;
		s.r = r;
		s.chk = chk;
		s.want = w;
		rows.push_back(s);
	endfunction

	// valid drops only while the sender idles; held across back-to-back sends
	task automatic send(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		predict_timer_rsp(r);
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (!req_ready);
	endtask

	function automatic req_t rand_req();
		req_t r;
		int p;
		p = $urandom_range(99);
		r = '0;
		r.timer_id = 3'($urandom_range(7));
		r.event_token = 16'($urandom);
		if (p < 55) begin
			r.mode = MODE_START;
			case ($urandom_range(3))
				0: r.duration = $urandom;
				1: r.duration = $urandom_range(15);
				default: r.duration = $urandom_range(4000);
			endcase
		end else if (p < 72) begin
			r.mode = MODE_STOP;
		end else if (p < 96) begin
			r.mode = MODE_EXPIRE;
		end else begin
			r.mode = MODE_NONE;
		end
		case ($urandom_range(3))
			0: r.elapsed = 28'($urandom);
			1: r.elapsed = 0;
			default: r.elapsed = 28'($urandom_range(300));
		endcase
		return r;
	endfunction

	initial begin
		rsp_t w;
		head = EMPTY;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			nxt[i] = EMPTY;
			dlt[i] = 0;
			running[i] = 1'b0;
			tok[i] = '0;
		end
		w = '0;
		add_row(mk(MODE_EXPIRE, 0, 0, 0, 0), 1, one(KIND_IDLE, 0));
		add_row(mk(MODE_STOP, 3, 0, 0, 0), 1, one(KIND_IDLE, 0));
		add_row(mk(MODE_NONE, 7, '1, '1, '1), 1, one(KIND_IDLE, 0));
		add_row(mk(MODE_START, 0, 0, 16'h0001, 0), 1, one(KIND_PROGRAM, 1));
		add_row(mk(MODE_STOP, 0, 0, 0, 0), 1, one(KIND_STOP, 0));
		add_row(mk(MODE_START, 7, '1, 16'hFFFF, '1), 1, one(KIND_PROGRAM, DELTA_MAX));
		add_row(mk(MODE_START, 1, 32'd160, 16'hA001, 0), 0, w);
		add_row(mk(MODE_START, 2, 32'd160, 16'hA002, 0), 0, w);
		add_row(mk(MODE_START, 3, 32'd80, 16'hA003, 5), 0, w);
		add_row(mk(MODE_START, 4, 32'd15, 16'hA004, 0), 0, w);
		add_row(mk(MODE_START, 3, 32'd400, 16'hA033, 1), 0, w);
		add_row(mk(MODE_STOP, 2, 0, 0, 0), 0, w);
		add_row(mk(MODE_STOP, 5, 0, 0, 0), 0, w);
		add_row(mk(MODE_EXPIRE, 0, 0, 0, 3), 0, w);
		add_row(mk(MODE_START, 5, 32'h0000_0100, 16'h5555, 28'hFFF_FFFF), 0, w);
		add_row(mk(MODE_EXPIRE, 0, 0, 0, 28'hFFF_FFFF), 0, w);
		add_row(mk(MODE_START, 6, 32'hFFFF_FFFF, 16'h0000, 0), 0, w);
		add_row(mk(MODE_START, 6, 32'h0000_0040, 16'h6666, 0), 0, w);
		add_row(mk(MODE_EXPIRE, 0, 0, 0, 28'hFFF_FFFF), 0, w);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// no hold-off needed after reset beyond the ready handshake
		foreach (rows[i]) begin
			if (rows[i].chk && rows[i].want !== '0) begin
				// typed-in expectation must agree with the predictor as well
				send(rows[i].r);
				if (pending_rsp[pending_rsp.size()-1] !== rows[i].want)
					note_mismatch(rows[i].want, pending_rsp[pending_rsp.size()-1]);
			end else begin
				send(rows[i].r);
			end
		end
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 61 : 0;
			recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 32 : 0;
			repeat (30)
				send(rand_req());
		end
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/dlq_pkg.sv
rtl/core/dlq_cell.sv
rtl/core/dlq_ctrl.sv
rtl/core/delta_list_timer_queue_core.sv
dv/delta_list_timer_queue_core_tb.sv
